// ===== hw/rtl/iafp_pkg.sv =====
package iafp_pkg;

  localparam logic [7:0] HDR_BYTE   = 8'h55;
  localparam logic [7:0] ANGLE_TYPE = 8'h53;
  localparam int         FRAME_LEN  = 11;
  localparam logic [3:0] LAST_POS   = 4'(FRAME_LEN - 1);

  localparam int QUEUE_DEPTH = 2;

  // (2^24 - 1) / 85 is exact, so d * RECIP_85 >> 24 is d / 85 or one below it.
  localparam int         RECIP_SHIFT = 24;
  localparam logic [17:0] RECIP_85   = 18'd197379;
  localparam logic [22:0] TEMP_DIV   = 23'd85;
  localparam logic [22:0] TEMP_BIAS  = 23'd2097205;
  localparam logic [16:0] TEMP_SHIFT = 17'd15393;
  localparam logic signed [21:0] ANGLE_MUL = 22'sd45;

  typedef struct packed {
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic signed [15:0] yaw;
    logic signed [15:0] temp;
  } raw_frame_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

// ===== hw/rtl/iafp_front.sv =====
module iafp_front import iafp_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    in_rx_byte,
  input  queue_status_t q_status,
  output logic          push,
  output raw_frame_t    push_frame
);

  logic [3:0] pos_r, pos_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [7:0] frame_r [FRAME_LEN - 1];
  logic       accept;
  logic       hunting;
  logic       body_byte;

  assign in_ready  = !((pos_r == LAST_POS) && q_status.full);
  assign accept    = in_valid && in_ready;
  assign hunting   = (pos_r == 4'd0) || (pos_r > LAST_POS);
  assign body_byte = !hunting && (pos_r < LAST_POS);

  always_comb begin
    pos_nxt = pos_r;
    sum_nxt = sum_r;
    push    = 1'b0;
    if (accept) begin
      if (hunting) begin
        if (in_rx_byte == HDR_BYTE) begin
          pos_nxt = 4'd1;
          sum_nxt = in_rx_byte;
        end else begin
          pos_nxt = 4'd0;
        end
      end else if (body_byte) begin
        pos_nxt = pos_r + 4'd1;
        sum_nxt = sum_r + in_rx_byte;
      end else begin
        pos_nxt = 4'd0;
        push    = (frame_r[1] == ANGLE_TYPE) && (sum_r == in_rx_byte);
      end
    end
  end

  assign push_frame.roll  = {frame_r[3], frame_r[2]};
  assign push_frame.pitch = {frame_r[5], frame_r[4]};
  assign push_frame.yaw   = {frame_r[7], frame_r[6]};
  assign push_frame.temp  = {frame_r[9], frame_r[8]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= 4'd0;
      sum_r <= 8'd0;
    end else begin
      pos_r <= pos_nxt;
      sum_r <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (body_byte || (hunting && (in_rx_byte == HDR_BYTE)))) begin
      frame_r[hunting ? 4'd0 : pos_r] <= in_rx_byte;
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= LAST_POS) else $error("byte position out of range");

  a_push_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (accept && (pos_r == LAST_POS) && !q_status.full))
    else $error("frame pushed away from the checksum word");

  a_hunt_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && hunting && (in_rx_byte != HDR_BYTE)) |=> (pos_r == 4'd0))
    else $error("non-header word left the hunt");

endmodule

// ===== hw/rtl/iafp_queue.sv =====
module iafp_queue import iafp_pkg::*; #(
  parameter int Depth = QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  raw_frame_t    push_frame,
  input  logic          pop,
  output raw_frame_t    head_frame,
  output queue_status_t q_status
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  raw_frame_t        mem_r [Depth];
  logic [PtrW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]   count_r, count_nxt;

  assign q_status.full  = (count_r == CntW'(Depth));
  assign q_status.empty = (count_r == '0);
  assign head_frame     = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + PtrW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CntW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_frame;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(Depth)) else $error("queue count overflow");

  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_status.full) else $error("push into a full queue");

  a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_status.empty) else $error("pop from an empty queue");

endmodule

// ===== hw/rtl/iafp_back.sv =====
module iafp_back import iafp_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  queue_status_t      q_status,
  input  raw_frame_t          head_frame,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [16:0]  out_roll_angle,
  output logic signed [16:0]  out_pitch_angle,
  output logic signed [16:0]  out_yaw_angle,
  output logic signed [16:0]  out_temperature
);

  logic               s1_valid_r, s1_valid_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic signed [16:0] s1_roll_r, s1_pitch_r, s1_yaw_r;
  logic [21:0]        s1_dividend_r;
  logic [15:0]        s1_quot_r;
  logic signed [16:0] roll_r, pitch_r, yaw_r, temp_r;

  logic               out_adv;
  logic               s1_adv;
  logic signed [21:0] roll_prod, pitch_prod, yaw_prod;
  logic [22:0]        dividend_sum;
  logic [39:0]        recip_prod;
  logic [22:0]        remainder;
  logic [16:0]        quot;

  assign out_adv = !out_valid_r || out_ready;
  assign s1_adv  = s1_valid_r && out_adv;
  assign pop     = !q_status.empty && (!s1_valid_r || out_adv);

  // Floor of raw * 45 / 32 is an arithmetic shift of the product.
  assign roll_prod  = 22'(head_frame.roll) * ANGLE_MUL;
  assign pitch_prod = 22'(head_frame.pitch) * ANGLE_MUL;
  assign yaw_prod   = 22'(head_frame.yaw) * ANGLE_MUL;

  // The bias keeps the dividend positive so that the quotient floors.
  assign dividend_sum = {head_frame.temp[15], head_frame.temp, 6'b0} + TEMP_BIAS;
  assign recip_prod   = 40'(dividend_sum[21:0]) * 40'(RECIP_85);

  assign remainder = 23'(s1_dividend_r) - 23'(s1_quot_r) * TEMP_DIV;
  assign quot      = 17'(s1_quot_r) + 17'(remainder >= TEMP_DIV);

  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    out_valid_nxt = out_valid_r;
    if (out_adv) begin
      out_valid_nxt = s1_valid_r;
    end
    if (pop) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_roll_r     <= roll_prod[21:5];
      s1_pitch_r    <= pitch_prod[21:5];
      s1_yaw_r      <= yaw_prod[21:5];
      s1_dividend_r <= dividend_sum[21:0];
      s1_quot_r     <= recip_prod[RECIP_SHIFT +: 16];
    end
    if (s1_adv) begin
      roll_r  <= s1_roll_r;
      pitch_r <= s1_pitch_r;
      yaw_r   <= s1_yaw_r;
      temp_r  <= signed'(quot - TEMP_SHIFT);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_roll_angle  = roll_r;
  assign out_pitch_angle = pitch_r;
  assign out_yaw_angle   = yaw_r;
  assign out_temperature = temp_r;

  a_remainder_bound: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> (remainder < (TEMP_DIV << 1)))
    else $error("reciprocal quotient off by more than one");

  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_adv) |=> s1_valid_r)
    else $error("first stage lost a frame while stalled");

  a_pop_space: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (!s1_valid_r || out_adv))
    else $error("frame popped into an occupied stage");

endmodule

// ===== hw/rtl/imu_angle_frame_parser.sv =====
// Takes one serial word per cycle and returns one result, three angles and a temperature
// in 1/256 units, for each 11-word frame of type 0x53 whose checksum matches; other frames
// and words outside a frame are dropped without a trace. The byte assembler accepts a word
// every cycle and stalls only on the checksum word while the frame queue (QueueDepth
// entries) is full. With the queue empty and the output free, a frame whose checksum word
// is taken is written into the frame queue, moves from the queue into the conversion stage
// and from there reaches the output register.
module imu_angle_frame_parser import iafp_pkg::*; #(
  parameter int QueueDepth = QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [16:0] out_roll_angle,
  output logic signed [16:0] out_pitch_angle,
  output logic signed [16:0] out_yaw_angle,
  output logic signed [16:0] out_temperature
);

  queue_status_t q_status;
  logic          push;
  logic          pop;
  raw_frame_t    push_frame;
  raw_frame_t    head_frame;

  iafp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .q_status   (q_status),
    .push       (push),
    .push_frame (push_frame)
  );

  iafp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_frame (push_frame),
    .pop        (pop),
    .head_frame (head_frame),
    .q_status   (q_status)
  );

  iafp_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_status        (q_status),
    .head_frame      (head_frame),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_roll_angle  (out_roll_angle),
    .out_pitch_angle (out_pitch_angle),
    .out_yaw_angle   (out_yaw_angle),
    .out_temperature (out_temperature)
  );

endmodule
